// ===== sv/gbat_pkg.sv =====
// Shared types and constants for the group-by aggregation table.
`default_nettype none

package gbat_pkg;

  localparam int MAX_GROUPS_DEF = 16;
  localparam int RESULT_CAP     = 16;

  localparam int KEY_W  = 16;
  localparam int CNT_W  = 16;
  localparam int QTY_W  = 16;
  localparam int PRC_W  = 20;
  localparam int PROD_W = QTY_W + PRC_W;
  localparam int QSUM_W = 32;
  localparam int VSUM_W = 48;

  typedef enum logic [1:0] {
    CMD_RECORD  = 2'd0,
    CMD_READOUT = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CREATED = 3'd0,
    ST_UPDATED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_READOUT = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LEFT  = 3'd1,
    CELL_RIGHT = 3'd2,
    CELL_WRAP  = 3'd3,
    CELL_NEW   = 3'd4,
    CELL_ACC   = 3'd5
  } cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
    logic [QSUM_W-1:0] qsum;
    logic [VSUM_W-1:0] vsum;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/gbat_cell.sv =====
// One table cell: holds a group, compares its key, accumulates, shifts to neighbors.
`default_nettype none

module gbat_cell import gbat_pkg::*; (
  input  wire logic              clk_i,
  input  wire cell_op_e          op_i,
  input  wire entry_t            left_i,
  input  wire entry_t            right_i,
  input  wire entry_t            wrap_i,
  input  wire entry_t            new_i,
  input  wire logic [KEY_W-1:0]  code_i,
  input  wire logic [QTY_W-1:0]  qty_i,
  input  wire logic [PROD_W-1:0] prod_i,
  output entry_t                 entry_o,
  output entry_t                 acc_o,
  output cell_stat_t             stat_o
);

  entry_t entry_q, entry_d;
  logic [CNT_W:0]  cnt_sum;
  logic [QSUM_W:0] qty_sum;
  logic [VSUM_W:0] val_sum;

  always_comb begin
    cnt_sum = {1'b0, entry_q.cnt} + {{CNT_W{1'b0}}, 1'b1};
    qty_sum = {1'b0, entry_q.qsum} + {{(QSUM_W + 1 - QTY_W){1'b0}}, qty_i};
    val_sum = {1'b0, entry_q.vsum} + {{(VSUM_W + 1 - PROD_W){1'b0}}, prod_i};
    acc_o.key  = entry_q.key;
    acc_o.cnt  = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
    acc_o.qsum = qty_sum[QSUM_W] ? {QSUM_W{1'b1}} : qty_sum[QSUM_W-1:0];
    acc_o.vsum = val_sum[VSUM_W] ? {VSUM_W{1'b1}} : val_sum[VSUM_W-1:0];
  end

  always_comb begin
    case (op_i)
      CELL_HOLD:  entry_d = entry_q;
      CELL_LEFT:  entry_d = left_i;
      CELL_RIGHT: entry_d = right_i;
      CELL_WRAP:  entry_d = wrap_i;
      CELL_NEW:   entry_d = new_i;
      CELL_ACC:   entry_d = acc_o;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign stat_o.eq = (entry_q.key == code_i);
  assign stat_o.gt = (entry_q.key > code_i);

endmodule

`default_nettype wire

// ===== sv/group_by_aggregate_table.sv =====
// Top level of the group-by aggregation table: control, cell row and result register.
//
// Requests enter on start/busy: a request is taken at a clock edge with start high
// and busy low. cmd selects record (0), sorted readout (1) or clear (2); code 3 is
// ignored. Results leave on valid_o for one cycle each, with last_o on the final one.
// The groups sit in a row of cells kept sorted by code: a new group is inserted by
// shifting the larger entries one cell up, so a readout is a rotation of the row.
// Record: S_CALC registers the product, then in S_APPLY the cell update and the
// result register take the same edge; busy through both states.
// Readout: one row per cycle from cell 0 while the row rotates, first row in the
// first S_READ cycle; busy until all used cells have passed cell 0.
// An empty table gives no rows. At most RESULT_CAP rows (lowest codes) are reported.
// Clear: one result on the cycle after the request edge; one request per cycle.
// Reset empties the table at once; no clearing pass is needed.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

module group_by_aggregate_table import gbat_pkg::*; #(
  parameter int MaxGroups = MAX_GROUPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [KEY_W-1:0]  code_i,
  input  wire logic [QTY_W-1:0]  quantity_i,
  input  wire logic [PRC_W-1:0]  unit_price_i,
  output logic                   valid_o,
  output logic [2:0]             status_o,
  output logic [KEY_W-1:0]       group_code_o,
  output logic [CNT_W-1:0]       occurrences_o,
  output logic [QSUM_W-1:0]      total_quantity_o,
  output logic [VSUM_W-1:0]      total_value_o,
  output logic                   last_o
);

  localparam int CntW = $clog2(MaxGroups + 1);
  localparam int NCap = (RESULT_CAP < MaxGroups) ? RESULT_CAP : MaxGroups;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_APPLY = 4'b0100,
    S_READ  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] rows_n;

  logic [KEY_W-1:0]  code_q;
  logic [QTY_W-1:0]  qty_q;
  logic [PRC_W-1:0]  price_q;
  logic [PROD_W-1:0] prod_q;

  logic              valid_q, valid_d;
  status_e           status_q, status_d;
  entry_t            res_q, res_d;
  logic              last_q, last_d;

  cell_op_e   ops   [MaxGroups];
  entry_t     ent   [MaxGroups];
  entry_t     acc   [MaxGroups];
  cell_stat_t stat  [MaxGroups];
  logic [MaxGroups-1:0] vld, hit, ge;
  logic       any_hit, full, accept;
  entry_t     acc_sel, new_ent;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign full   = (used_q == CntW'(MaxGroups));
  assign rows_n = (used_q > CntW'(NCap)) ? CntW'(NCap) : used_q;

  assign new_ent.key  = code_q;
  assign new_ent.cnt  = {{(CNT_W - 1){1'b0}}, 1'b1};
  assign new_ent.qsum = {{(QSUM_W - QTY_W){1'b0}}, qty_q};
  assign new_ent.vsum = {{(VSUM_W - PROD_W){1'b0}}, prod_q};

  always_comb begin
    acc_sel = '0;
    for (int i = 0; i < MaxGroups; i++) begin
      vld[i] = (CntW'(i) < used_q);
      hit[i] = vld[i] && stat[i].eq;
      ge[i]  = !vld[i] || stat[i].gt;
      if (hit[i]) begin
        acc_sel = acc_sel | acc[i];
      end
    end
    any_hit = |hit;
  end

  always_comb begin
    for (int i = 0; i < MaxGroups; i++) begin
      ops[i] = CELL_HOLD;
      if (state_q == S_APPLY) begin
        if (any_hit) begin
          if (hit[i]) begin
            ops[i] = CELL_ACC;
          end
        end else if (!full) begin
          if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
            ops[i] = CELL_LEFT;
          end else if (ge[i]) begin
            ops[i] = CELL_NEW;
          end
        end
      end else if (state_q == S_READ) begin
        if (CntW'(i + 1) < used_q) begin
          ops[i] = CELL_RIGHT;
        end else if (CntW'(i + 1) == used_q) begin
          ops[i] = CELL_WRAP;
        end
      end
    end
  end

  for (genvar g = 0; g < MaxGroups; g++) begin : g_cell
    entry_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[g-1];
    end
    if (g == MaxGroups - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent[g+1];
    end
    gbat_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ops[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .wrap_i  (ent[0]),
      .new_i   (new_ent),
      .code_i  (code_q),
      .qty_i   (qty_q),
      .prod_i  (prod_q),
      .entry_o (ent[g]),
      .acc_o   (acc[g]),
      .stat_o  (stat[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    rd_d     = rd_q;
    valid_d  = 1'b0;
    status_d = status_q;
    res_d    = res_q;
    last_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_RECORD: state_d = S_CALC;
            CMD_READOUT: begin
              rd_d = '0;
              if (used_q != '0) begin
                state_d = S_READ;
              end
            end
            CMD_CLEAR: begin
              used_d   = '0;
              valid_d  = 1'b1;
              status_d = ST_CLEARED;
              res_d    = '0;
              last_d   = 1'b1;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CALC: state_d = S_APPLY;
      S_APPLY: begin
        state_d = S_IDLE;
        valid_d = 1'b1;
        last_d  = 1'b1;
        if (any_hit) begin
          status_d = ST_UPDATED;
          res_d    = acc_sel;
        end else if (full) begin
          status_d  = ST_DROPPED;
          res_d     = '0;
          res_d.key = code_q;
        end else begin
          status_d = ST_CREATED;
          res_d    = new_ent;
          used_d   = used_q + CntW'(1);
        end
      end
      S_READ: begin
        valid_d  = (rd_q < rows_n);
        status_d = ST_READOUT;
        res_d    = ent[0];
        last_d   = ((rd_q + CntW'(1)) == rows_n);
        rd_d     = rd_q + CntW'(1);
        if ((rd_q + CntW'(1)) == used_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      rd_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      rd_q    <= rd_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q  <= code_i;
      qty_q   <= quantity_i;
      price_q <= unit_price_i;
    end
    if (state_q == S_CALC) begin
      prod_q <= PROD_W'(qty_q * price_q);
    end
    status_q <= status_d;
    res_q    <= res_d;
    last_q   <= last_d;
  end

  assign valid_o          = valid_q;
  assign status_o         = status_q;
  assign group_code_o     = res_q.key;
  assign occurrences_o    = res_q.cnt;
  assign total_quantity_o = res_q.qsum;
  assign total_value_o    = res_q.vsum;
  assign last_o           = last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MaxGroups))
    else $error("group count beyond table size");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot0(hit))
    else $error("code matches more than one group");

  a_row_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == ST_READOUT) |-> $past(state_q == S_READ))
    else $error("readout row outside readout");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == ST_CLEARED) |-> (used_q == '0))
    else $error("table not empty after clear");

endmodule

`default_nettype wire

// ===== tb/group_by_aggregate_table_tb.sv =====
// Self-checking testbench for the group-by aggregation table: queued requests, predictor, monitor.
`default_nettype none

module group_by_aggregate_table_tb;
  import gbat_pkg::*;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam logic [63:0] QSUM_MAX = (64'd1 << QSUM_W) - 1;
  localparam logic [63:0] VSUM_MAX = (64'd1 << VSUM_W) - 1;
  localparam int          RANDOM_REQS = 400;
  localparam int          SAT_RECORDS = 40;
  localparam int          CYCLE_LIMIT = 5000000;
  localparam int          TAIL_CYCLES = 40;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] code;
    logic [QTY_W-1:0] qty;
    logic [PRC_W-1:0] price;
    logic             drain;
    logic             tight;
  } request_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [KEY_W-1:0]  code;
    logic [CNT_W-1:0]  cnt;
    logic [QSUM_W-1:0] qsum;
    logic [VSUM_W-1:0] vsum;
    logic              last;
  } result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd_i = 2'd0;
  logic [KEY_W-1:0]  code_i = '0;
  logic [QTY_W-1:0]  quantity_i = '0;
  logic [PRC_W-1:0]  unit_price_i = '0;
  logic              valid_o;
  logic [2:0]        status_o;
  logic [KEY_W-1:0]  group_code_o;
  logic [CNT_W-1:0]  occurrences_o;
  logic [QSUM_W-1:0] total_quantity_o;
  logic [VSUM_W-1:0] total_value_o;
  logic              last_o;

  request_t request_fifo[$];
  result_t  due_results[$];
  entry_t   grp_tab[MAX_GROUPS_DEF];
  int       grp_used = 0;
  int       idle_left = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  result_t  seen;

  group_by_aggregate_table uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .code_i           (code_i),
    .quantity_i       (quantity_i),
    .unit_price_i     (unit_price_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .group_code_o     (group_code_o),
    .occurrences_o    (occurrences_o),
    .total_quantity_o (total_quantity_o),
    .total_value_o    (total_value_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] lim);
    if (b >= lim - a) return lim;
    return a + b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(20, 4);
  endfunction

  task automatic post_result(input status_e st, input logic [KEY_W-1:0] key,
                             input logic [CNT_W-1:0] cnt, input logic [QSUM_W-1:0] qsum,
                             input logic [VSUM_W-1:0] vsum, input logic last);
    result_t r;
    r.status = st;
    r.code = key;
    r.cnt = cnt;
    r.qsum = qsum;
    r.vsum = vsum;
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic aggregate_request(input request_t rq);
    int ord[MAX_GROUPS_DEF];
    int hit, n, i, j, t;
    logic [PROD_W-1:0] prod;
    hit = -1;
    prod = rq.qty * rq.price;
    case (rq.cmd)
      CMD_RECORD: begin
        for (i = 0; i < grp_used; i++) begin
          if (grp_tab[i].key == rq.code) hit = i;
        end
        if (hit >= 0) begin
          grp_tab[hit].cnt = CNT_W'(sat_sum(64'(grp_tab[hit].cnt), 64'd1, CNT_MAX));
          grp_tab[hit].qsum = QSUM_W'(sat_sum(64'(grp_tab[hit].qsum), 64'(rq.qty),
                                              QSUM_MAX));
          grp_tab[hit].vsum = VSUM_W'(sat_sum(64'(grp_tab[hit].vsum), 64'(prod),
                                              VSUM_MAX));
          post_result(ST_UPDATED, rq.code, grp_tab[hit].cnt, grp_tab[hit].qsum,
                      grp_tab[hit].vsum, 1'b1);
        end else if (grp_used >= MAX_GROUPS_DEF) begin
          post_result(ST_DROPPED, rq.code, '0, '0, '0, 1'b1);
        end else begin
          grp_tab[grp_used].key = rq.code;
          grp_tab[grp_used].cnt = CNT_W'(1);
          grp_tab[grp_used].qsum = QSUM_W'(rq.qty);
          grp_tab[grp_used].vsum = VSUM_W'(prod);
          grp_used++;
          post_result(ST_CREATED, rq.code, CNT_W'(1), QSUM_W'(rq.qty), VSUM_W'(prod),
                      1'b1);
        end
      end
      CMD_READOUT: begin
        for (i = 0; i < grp_used; i++) begin
          j = i;
          while (j > 0 && grp_tab[ord[j-1]].key > grp_tab[i].key) begin
            ord[j] = ord[j-1];
            j--;
          end
          ord[j] = i;
        end
        n = (grp_used < RESULT_CAP) ? grp_used : RESULT_CAP;
        for (i = 0; i < n; i++) begin
          t = ord[i];
          post_result(ST_READOUT, grp_tab[t].key, grp_tab[t].cnt, grp_tab[t].qsum,
                      grp_tab[t].vsum, i == n - 1);
        end
      end
      CMD_CLEAR: begin
        grp_used = 0;
        post_result(ST_CLEARED, '0, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic queue_request(input logic [1:0] cmd, input logic [KEY_W-1:0] code,
                               input logic [QTY_W-1:0] qty, input logic [PRC_W-1:0] price,
                               input logic drain, input logic tight);
    request_t rq;
    rq.cmd = cmd;
    rq.code = code;
    rq.qty = qty;
    rq.price = price;
    rq.drain = drain;
    rq.tight = tight;
    request_fifo.push_back(rq);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= CMD_RECORD;
      code_i <= '0;
      quantity_i <= '0;
      unit_price_i <= '0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        aggregate_request(request_fifo[0]);
        request_fifo.delete(0);
        if (request_fifo.size() > 0 && request_fifo[0].tight) idle_left = 0;
        else idle_left = pick_gap();
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (request_fifo.size() > 0 &&
                     (!request_fifo[0].drain || due_results.size() == 0)) begin
          start <= 1'b1;
          cmd_i <= request_fifo[0].cmd;
          code_i <= request_fifo[0].code;
          quantity_i <= request_fifo[0].qty;
          unit_price_i <= request_fifo[0].price;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d code %0h",
                 $time, status_o, group_code_o);
        mismatch_count++;
      end else begin
        seen = due_results.pop_front();
        check_field("status", 64'(seen.status), 64'(status_o));
        check_field("group_code", 64'(seen.code), 64'(group_code_o));
        check_field("occurrences", 64'(seen.cnt), 64'(occurrences_o));
        check_field("total_quantity", 64'(seen.qsum), 64'(total_quantity_o));
        check_field("total_value", 64'(seen.vsum), 64'(total_value_o));
        check_field("last", 64'(seen.last), 64'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL group_by_aggregate_table");
      $finish;
    end
  end

  function automatic logic [QTY_W-1:0] pick_qty();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return QTY_W'($urandom_range(15, 1));
      default: return QTY_W'($urandom);
    endcase
  endfunction

  function automatic logic [PRC_W-1:0] pick_price();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return PRC_W'($urandom_range(999, 1));
      default: return PRC_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [KEY_W-1:0] pool[24];
    int pool_n, r, k;

    queue_request(CMD_READOUT, '0, '0, '0, 1'b0, 1'b0);
    queue_request(CMD_UNUSED, '1, '1, '1, 1'b0, 1'b0);
    queue_request(CMD_RECORD, '0, '0, '0, 1'b0, 1'b0);
    queue_request(CMD_RECORD, '1, '1, '1, 1'b0, 1'b0);
    queue_request(CMD_RECORD, '1, 16'd1, 20'd1, 1'b0, 1'b0);
    queue_request(CMD_READOUT, '0, '0, '0, 1'b1, 1'b0);
    queue_request(CMD_CLEAR, '1, '1, '1, 1'b0, 1'b0);
    queue_request(CMD_READOUT, '0, '0, '0, 1'b0, 1'b0);
    for (k = 0; k < MAX_GROUPS_DEF; k++) begin
      queue_request(CMD_RECORD, KEY_W'(16'hF000 - k * 16'h0E00), pick_qty(), pick_price(),
                    1'b0, 1'b0);
    end
    queue_request(CMD_RECORD, 16'h1234, 16'd7, 20'd300, 1'b0, 1'b0);
    queue_request(CMD_RECORD, 16'hF000, 16'd7, 20'd300, 1'b0, 1'b0);
    queue_request(CMD_READOUT, '0, '0, '0, 1'b0, 1'b0);

    // drive one group back to back with the largest operands
    queue_request(CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0);
    for (k = 0; k < SAT_RECORDS; k++) begin
      queue_request(CMD_RECORD, 16'hA5A5, '1, '1, 1'b0, 1'b1);
    end
    queue_request(CMD_READOUT, '0, '0, '0, 1'b0, 1'b0);
    queue_request(CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0);

    pool_n = 0;
    for (k = 0; k < RANDOM_REQS; k++) begin
      if (pool_n == 0) begin
        pool_n = $urandom_range(24, 4);
        for (r = 0; r < pool_n; r++) begin
          case ($urandom_range(9, 0))
            0: pool[r] = '0;
            1: pool[r] = '1;
            default: pool[r] = KEY_W'($urandom);
          endcase
        end
      end
      r = $urandom_range(99, 0);
      if (r < 85) begin
        queue_request(CMD_RECORD,
                      ($urandom_range(9, 0) == 0) ? KEY_W'($urandom) :
                                                     pool[$urandom_range(pool_n - 1, 0)],
                      pick_qty(), pick_price(), $urandom_range(99, 0) < 3, 1'b0);
      end else if (r < 94) begin
        queue_request(CMD_READOUT, KEY_W'($urandom), QTY_W'($urandom), PRC_W'($urandom),
                      $urandom_range(99, 0) < 10, 1'b0);
      end else if (r < 97) begin
        queue_request(CMD_CLEAR, KEY_W'($urandom), QTY_W'($urandom), PRC_W'($urandom),
                      1'b0, 1'b0);
        pool_n = 0;
      end else begin
        queue_request(CMD_UNUSED, KEY_W'($urandom), QTY_W'($urandom), PRC_W'($urandom),
                      1'b0, 1'b0);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_fifo.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS group_by_aggregate_table");
    end else begin
      $display("FAIL group_by_aggregate_table");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== group_by_aggregate_table.f =====
sv/gbat_pkg.sv
sv/gbat_cell.sv
sv/group_by_aggregate_table.sv
tb/group_by_aggregate_table_tb.sv
